FILE: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sorted list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int unsigned SLE_CAPACITY = 16;  // default number of list cells
  localparam int unsigned SLE_QDEPTH   = 2;   // default depth of the internal queues
  localparam int unsigned SLE_DATA_W   = 32;
  localparam int unsigned SLE_POS_W    = 8;
  localparam int unsigned SLE_LEN_W    = 5;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DEL_FIRST = 2'd1,
    OP_DEL_LAST  = 2'd2,
    OP_DEL_AT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [SLE_DATA_W-1:0] value;
    logic [SLE_POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [SLE_DATA_W-1:0] removed_value;
    logic [SLE_LEN_W-1:0]         length;
    logic signed [SLE_DATA_W-1:0] smallest;
    logic signed [SLE_DATA_W-1:0] largest;
  } out_item_t;

  // Command as classified by the front end
  typedef struct packed {
    op_e                          kind;
    logic signed [SLE_DATA_W-1:0] value;
    logic                         pos_nz;   // position is non-zero
    logic [SLE_POS_W-1:0]         pos_idx;  // position minus one
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/sle_fifo.sv
// ----------------------------------------------------------------------------
// sle_fifo
// Small register queue; Depth must be a power of two, at least 2.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_fifo
  import sle_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = SLE_QDEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front
// Takes input items, decodes the opcode and prepares the position, and
// queues the command for the list core.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front
  import sle_pkg::*;
#(
  parameter int unsigned QDepth = SLE_QDEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t in_item_i,
  input  wire logic     cmd_pop_i,
  output cmd_t          cmd_o,
  output logic          cmd_empty_o
);

  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  always_comb begin
    unique case (in_item_i.opcode)
      OP_INSERT:    cmd_in.kind = OP_INSERT;
      OP_DEL_FIRST: cmd_in.kind = OP_DEL_FIRST;
      OP_DEL_LAST:  cmd_in.kind = OP_DEL_LAST;
      OP_DEL_AT:    cmd_in.kind = OP_DEL_AT;
      default:      cmd_in.kind = OP_INSERT;
    endcase
    cmd_in.value   = in_item_i.value;
    cmd_in.pos_nz  = (in_item_i.position != '0);
    cmd_in.pos_idx = in_item_i.position - 1'b1;
  end

  sle_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (QDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

`default_nettype wire

FILE: sv/sle_core.sv
// ----------------------------------------------------------------------------
// sle_core
// Row of list cells; each cell compares and shifts, so an insert or a
// delete completes in the same cycle that its command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_core
  import sle_pkg::*;
#(
  parameter int unsigned Capacity = SLE_CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_empty_i,
  output logic       cmd_pop_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output out_item_t  res_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic signed [SLE_DATA_W-1:0] entries_q [Capacity];
  logic signed [SLE_DATA_W-1:0] entries_d [Capacity];
  logic signed [SLE_DATA_W-1:0] ins_val   [Capacity];
  logic signed [SLE_DATA_W-1:0] del_val   [Capacity];
  logic [Capacity-1:0]          gt;
  logic [CntW-1:0]              count_q, count_d, last_idx, del_idx, top_idx;
  logic                         fire, is_ins, is_full, is_empty, do_ins, do_del;
  logic signed [SLE_DATA_W-1:0] removed, largest;

  assign fire       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign is_ins   = (cmd_i.kind == OP_INSERT);
  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);
  assign do_ins   = fire && is_ins && !is_full;
  assign do_del   = fire && !is_ins && !is_empty;
  assign last_idx = count_q - 1'b1;

  always_comb begin
    unique case (cmd_i.kind)
      OP_DEL_FIRST: del_idx = '0;
      OP_DEL_LAST:  del_idx = last_idx;
      OP_DEL_AT: begin
        if (cmd_i.pos_nz && (cmd_i.pos_idx < SLE_POS_W'(count_q))) begin
          del_idx = CntW'(cmd_i.pos_idx);
        end else begin
          del_idx = last_idx;
        end
      end
      default:      del_idx = last_idx;
    endcase
  end

  // per-cell compare and neighbour selection
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign gt[i] = (CntW'(i) < count_q) && (entries_q[i] > cmd_i.value);

    if (i == 0) begin : g_head
      assign ins_val[i] = (gt[i] || count_q == '0) ? cmd_i.value : entries_q[i];
    end else begin : g_body
      assign ins_val[i] = gt[i-1] ? entries_q[i-1] :
                          (gt[i] || CntW'(i) == count_q) ? cmd_i.value : entries_q[i];
    end

    if (i + 1 < Capacity) begin : g_shift
      assign del_val[i] = (CntW'(i) >= del_idx) ? entries_q[i+1] : entries_q[i];
    end else begin : g_tail
      assign del_val[i] = entries_q[i];
    end

    assign entries_d[i] = do_ins ? ins_val[i] : (do_del ? del_val[i] : entries_q[i]);
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_del) begin
      count_d = count_q - 1'b1;
    end
  end

  assign top_idx = count_d - 1'b1;

  // one-hot selections over the cells
  always_comb begin
    removed = '0;
    largest = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (do_del && CntW'(i) == del_idx) begin
        removed = removed | entries_q[i];
      end
      if (count_d != '0 && CntW'(i) == top_idx) begin
        largest = largest | entries_d[i];
      end
    end
  end

  always_comb begin
    if (fire && is_ins && is_full) begin
      res_o.status = ST_FULL;
    end else if (fire && !is_ins && is_empty) begin
      res_o.status = ST_EMPTY;
    end else begin
      res_o.status = ST_DONE;
    end
    res_o.removed_value = removed;
    res_o.length        = SLE_LEN_W'(count_d);
    res_o.smallest      = (count_d != '0) ? entries_d[0] : '0;
    res_o.largest       = largest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins || do_del) begin
      for (int unsigned i = 0; i < Capacity; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("list count beyond capacity");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_ins && is_full) |=> $stable(count_q))
    else $error("rejected insert changed the count");

  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_del |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shorten the list by one");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entries_q[0] <= entries_q[1]))
    else $error("first two cells out of order");

endmodule

`default_nettype wire

FILE: sv/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted-list priority queue of signed 32-bit values with insert and
// three kinds of delete; each operation returns one status/summary result.
// ----------------------------------------------------------------------------
//
//   channel   | handshake               | payload
//   ----------+-------------------------+------------------------------------
//   input     | push / full             | in_item_i  (opcode, value, position)
//   result    | empty / pop             | out_item_o (status, removed_value,
//             |                         |   length, smallest, largest)
//
// Cycles: one operation per clock sustained while the result queue has room;
//   the list core inserts or deletes through its row of compare-and-shift cells.
// Path: each item is registered in the command queue, then its result in the result queue.
// Reset: list count goes to zero at once; no clearing pass over the cells.
// Stalls: command and result queues (QDepth each) let the input side keep
//   taking transfers while a result waits to be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = SLE_CAPACITY,  // 2 .. 31
  parameter int unsigned QDepth   = SLE_QDEPTH     // power of two, >= 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // input channel
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_item_i,
  // result channel
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_item_o
);

  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  logic      res_full, res_push;
  out_item_t res_in;
  logic [$bits(out_item_t)-1:0] res_raw;

  // front end: decode and queue commands
  sle_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  // back end: the sorted cell row; runs whenever a command waits and
  // the result queue has room
  sle_core #(
    .Capacity (CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the core from the consumer
  sle_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (QDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(res_raw);

endmodule

`default_nettype wire

FILE: verif/sorted_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Self-checking bench for the sorted list engine: a scoreboard model of the
// ordered list predicts each result summary, directed corner cases come
// first, then random fill/drain/mixed bursts under three idling regimes.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_tb
  import sle_pkg::*;
();

  localparam int unsigned CAPACITY      = SLE_CAPACITY;
  localparam int unsigned RANDOM_OPS    = 1275;       // split over three phases
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned REPORT_CAP    = 40;         // printed mismatches
  localparam longint      RUN_LIMIT     = 2_000_000;  // time units

  typedef logic signed [SLE_DATA_W-1:0] word_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT ports
  logic      push       = 1'b0;
  logic      full;
  in_item_t  op_item    = '0;
  logic      empty;
  logic      pop        = 1'b0;
  out_item_t result_item;

  sorted_list_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (op_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (result_item)
  );

  // Operations waiting to be sent, and summaries still owed by the DUT
  in_item_t  list_ops_to_send[$];
  out_item_t expected_summaries[$];

  // Scoreboard copy of the ordered list
  word_t       list_cells [CAPACITY];
  int unsigned list_len = 0;

  // Length as the generator expects it once every queued op has been applied;
  // only the length matters for shaping positions, and that ignores values.
  int unsigned planned_len = 0;
  int unsigned ops_queued  = 0;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  int unsigned mismatch_count   = 0;
  int unsigned results_checked  = 0;
  int unsigned ops_sent         = 0;
  int unsigned rejected_inserts = 0;
  int unsigned empty_deletes    = 0;
  int unsigned full_lists_seen  = 0;

  // --------------------------------------------------------------------------
  // List model: applies one operation and returns the summary it yields.
  // Inserts go after any equal entries; a delete at position 0 or beyond the
  // length takes the last entry.
  // --------------------------------------------------------------------------
  function automatic out_item_t apply_list_op(in_item_t cmd);
    out_item_t   summary;
    int unsigned slot;
    int unsigned k;
    summary        = '0;
    summary.status = ST_DONE;
    if (op_e'(cmd.opcode) == OP_INSERT) begin
      if (list_len >= CAPACITY) begin
        summary.status = ST_FULL;
      end else begin
        slot = list_len;
        while (slot > 0 && $signed(list_cells[slot-1]) > $signed(cmd.value)) begin
          list_cells[slot] = list_cells[slot-1];
          slot--;
        end
        list_cells[slot] = cmd.value;
        list_len++;
      end
    end else if (list_len == 0) begin
      summary.status = ST_EMPTY;
    end else begin
      case (op_e'(cmd.opcode))
        OP_DEL_FIRST: slot = 0;
        OP_DEL_AT: begin
          if (cmd.position >= 1 && cmd.position <= list_len) slot = cmd.position - 1;
          else slot = list_len - 1;
        end
        default: slot = list_len - 1;
      endcase
      summary.removed_value = list_cells[slot];
      for (k = slot; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
      list_len--;
    end
    summary.length = SLE_LEN_W'(list_len);
    if (list_len > 0) begin
      summary.smallest = list_cells[0];
      summary.largest  = list_cells[list_len-1];
    end
    return summary;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("MISMATCH %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transfer in per edge where push is high and full is low.
  // The model is stepped on the transfer, then the next push is decided once.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      op_item <= '0;
    end else begin
      if (push && !full) begin
        expected_summaries.push_back(apply_list_op(op_item));
        void'(list_ops_to_send.pop_front());
        ops_sent++;
      end
      if (list_ops_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        push    <= 1'b1;
        op_item <= list_ops_to_send[0];
      end else begin
        push    <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: a result transfer happens where pop is high and empty is low;
  // each one is checked field by field against the oldest owed summary.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_summaries.size() == 0) begin
          report_mismatch("result with nothing owed, status",
                          32'(result_item.status), '0);
        end else begin
          want = expected_summaries.pop_front();
          results_checked++;
          if (result_item.status !== want.status)
            report_mismatch("status", 32'(result_item.status), 32'(want.status));
          if (result_item.removed_value !== want.removed_value)
            report_mismatch("removed_value", result_item.removed_value, want.removed_value);
          if (result_item.length !== want.length)
            report_mismatch("length", 32'(result_item.length), 32'(want.length));
          if (result_item.smallest !== want.smallest)
            report_mismatch("smallest", result_item.smallest, want.smallest);
          if (result_item.largest !== want.largest)
            report_mismatch("largest", result_item.largest, want.largest);
          if (want.status == ST_FULL)  rejected_inserts++;
          if (want.status == ST_EMPTY) empty_deletes++;
          if (want.length == SLE_LEN_W'(CAPACITY)) full_lists_seen++;
        end
      end
      pop <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_op(op_e kind, word_t val, logic [SLE_POS_W-1:0] pos);
    in_item_t item;
    item.opcode   = kind;
    item.value    = val;
    item.position = pos;
    list_ops_to_send.push_back(item);
    ops_queued++;
    if (kind == OP_INSERT) begin
      if (planned_len < CAPACITY) planned_len++;
    end else if (planned_len > 0) begin
      planned_len--;
    end
  endtask

  // Mostly full-range values; a narrow pool forces plenty of duplicates
  function automatic word_t pick_value();
    word_t val;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = '0;
          default: val = '1;
        endcase
      end
      1, 2: begin
        val = $urandom_range(16);
        val = val - 8;
      end
      default: val = $urandom;
    endcase
    return val;
  endfunction

  function automatic logic [SLE_POS_W-1:0] pick_position();
    int unsigned lo;
    case ($urandom_range(7))
      0: return '0;
      1: begin
        lo = (planned_len + 1 > 255) ? 255 : planned_len + 1;
        return SLE_POS_W'($urandom_range(255, lo));
      end
      default: begin
        if (planned_len == 0) return SLE_POS_W'($urandom_range(255));
        return SLE_POS_W'($urandom_range(planned_len, 1));
      end
    endcase
  endfunction

  task automatic queue_delete(op_e kind);
    queue_op(kind, word_t'($urandom),
             (kind == OP_DEL_AT) ? pick_position() : SLE_POS_W'($urandom_range(255)));
  endtask

  // Random bursts: fills (often up to and past capacity), drains (often past
  // empty), mixed traffic around a working level, and a little raw noise.
  task automatic queue_random_ops(int unsigned count);
    int unsigned goal;
    int unsigned n;
    goal = ops_queued + count;
    while (ops_queued < goal) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          n = $urandom_range(CAPACITY + 2, 1);
          repeat (n) queue_op(OP_INSERT, pick_value(), SLE_POS_W'($urandom_range(255)));
        end
        3, 4: begin
          n = planned_len + $urandom_range(2);
          repeat (n) queue_delete(op_e'($urandom_range(3, 1)));
        end
        5: begin
          n = $urandom_range(8, 1);
          repeat (n) queue_op(op_e'($urandom_range(3)), word_t'($urandom),
                              SLE_POS_W'($urandom_range(255)));
        end
        default: begin
          n = $urandom_range(20, 4);
          repeat (n) begin
            if ($urandom_range(1)) queue_op(OP_INSERT, pick_value(),
                                            SLE_POS_W'($urandom_range(255)));
            else queue_delete(op_e'($urandom_range(3, 1)));
          end
        end
      endcase
    end
  endtask

  task automatic queue_directed_ops();
    // deletes of every kind on an empty list
    queue_op(OP_DEL_FIRST, 32'h1234_5678, 8'd1);
    queue_op(OP_DEL_LAST,  32'hffff_ffff, 8'd255);
    queue_op(OP_DEL_AT,    '0,            8'd0);
    // one-entry list emptied by a delete at a position beyond the length
    queue_op(OP_INSERT, 32'h7fff_ffff, 8'd0);
    queue_op(OP_DEL_AT, '0, 8'd255);
    // fill to capacity with extremes and repeated values
    queue_op(OP_INSERT, 32'h8000_0000, 8'd0);
    queue_op(OP_INSERT, 32'h7fff_ffff, 8'd0);
    queue_op(OP_INSERT, 32'd0,         8'd0);
    queue_op(OP_INSERT, 32'd0,         8'd255);
    queue_op(OP_INSERT, -32'sd1,       8'd0);
    queue_op(OP_INSERT, 32'd1,         8'd0);
    queue_op(OP_INSERT, 32'd5,         8'd0);
    queue_op(OP_INSERT, 32'd5,         8'd0);
    queue_op(OP_INSERT, -32'sd5,       8'd0);
    queue_op(OP_INSERT, 32'd100,       8'd0);
    queue_op(OP_INSERT, -32'sd100,     8'd0);
    queue_op(OP_INSERT, 32'h4000_0000, 8'd0);
    queue_op(OP_INSERT, 32'hc000_0000, 8'd0);
    queue_op(OP_INSERT, 32'h8000_0000, 8'd0);
    queue_op(OP_INSERT, 32'h7fff_ffff, 8'd0);
    queue_op(OP_INSERT, 32'd3,         8'd0);
    // full: turned away
    queue_op(OP_INSERT, 32'd42, 8'd0);
    // position equal to the length, then one beyond it, then position zero
    queue_op(OP_DEL_AT, '0, 8'd16);
    queue_op(OP_DEL_AT, '0, 8'd16);
    queue_op(OP_DEL_AT, '0, 8'd0);
  endtask

  // Phase gaps: wait on the falling edge so the driver sees a settled queue
  task automatic wait_for_drain();
    while (list_ops_to_send.size() != 0 || expected_summaries.size() != 0)
      @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed ops, then three random phases. The sender runs
  // dry between phases and so pauses until every owed summary has come back.
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_directed_ops();
    wait_for_drain();

    sender_idle_pct   = 7;
    receiver_idle_pct = 62;
    queue_random_ops(RANDOM_OPS / 3);
    wait_for_drain();

    sender_idle_pct   = 62;
    receiver_idle_pct = 7;
    queue_random_ops(RANDOM_OPS / 3);
    wait_for_drain();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    queue_random_ops(RANDOM_OPS / 3);
    wait_for_drain();

    // let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Ran %0d list operations, %0d summaries checked, %0d at full capacity",
             ops_sent, results_checked, full_lists_seen);
    $display("Inserts turned away: %0d, deletes on an empty list: %0d, mismatches: %0d",
             rejected_inserts, empty_deletes, mismatch_count);
    if (mismatch_count == 0 && expected_summaries.size() == 0) begin
      $display("sorted_list_engine regression: pass");
    end else begin
      $display("sorted_list_engine regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Watchdog expired with %0d ops unsent and %0d summaries owed",
             list_ops_to_send.size(), expected_summaries.size());
    $display("sorted_list_engine regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
